@@ rtl/core/arc_pkg.sv @@
// shared constants, command and result types for the arp responder cache
package arc_pkg;

	localparam int CACHE_DEPTH   = 16;
	localparam int PENDING_DEPTH = 8;
	localparam int CACHE_CNT_W   = $clog2(CACHE_DEPTH + 1);
	localparam int CACHE_IDX_W   = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;

	localparam int IP_W       = 32;
	localparam int MAC_W      = 48;
	localparam int OPER_W     = 16;
	localparam int IFACE_W    = 2;
	localparam int OUT_OPER_W = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 48;

	localparam logic [OPER_W-1:0]     OPER_REQUEST   = OPER_W'(1);
	localparam logic [OPER_W-1:0]     OPER_REPLY     = OPER_W'(2);
	localparam logic [OUT_OPER_W-1:0] OUT_OP_REQUEST = OUT_OPER_W'(1);
	localparam logic [OUT_OPER_W-1:0] OUT_OP_REPLY   = OUT_OPER_W'(2);
	localparam logic [CFG_IDX_W-1:0]  REG_SELF_IP    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0]  REG_SELF_MAC   = CFG_IDX_W'(1);
	localparam logic [MAC_W-1:0]      MAC_BCAST      = '1;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_ARP_REQ,
		CMD_ARP_REPLY,
		CMD_RESOLVE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [IP_W-1:0]    ip;
		logic [MAC_W-1:0]   mac;
		logic [IFACE_W-1:0] iface;
	} cmd_t;

	typedef struct packed {
		logic                  send_valid;
		logic [OUT_OPER_W-1:0] out_oper;
		logic [IFACE_W-1:0]    out_iface;
		logic [MAC_W-1:0]      eth_dest_mac;
		logic [IP_W-1:0]       out_target_ip;
		logic [MAC_W-1:0]      out_target_mac;
		logic                  learned;
		logic                  cache_full;
		logic                  pending_full;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_UPDATE
	} back_state_t;

endpackage

@@ rtl/core/arp_responder_cache.sv @@
// top level: arp offload engine with address cache and pending resolve store
// an item is buffered in the front queue; the back end then loads it, searches and registers its result
// the back end handles one item at a time, in the steps load, search, update, pop
// the back end takes a new command only after the previous result transfer
// reset: arst_n clears config registers, queue pointers, cache count and pending valid bits
// cache and pending address stores are not reset; only written entries are ever compared
module arp_responder_cache (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic                           req_type,
	input  logic [arc_pkg::OPER_W-1:0]     arp_oper,
	input  logic [arc_pkg::IP_W-1:0]       sender_ip,
	input  logic [arc_pkg::MAC_W-1:0]      sender_mac,
	input  logic [arc_pkg::IP_W-1:0]       target_ip,
	input  logic [arc_pkg::IP_W-1:0]       resolve_ip,
	input  logic [arc_pkg::IFACE_W-1:0]    iface,
	output logic                           empty,
	input  logic                           pop,
	output logic                           send_valid,
	output logic [arc_pkg::OUT_OPER_W-1:0] out_oper,
	output logic [arc_pkg::IFACE_W-1:0]    out_iface,
	output logic [arc_pkg::MAC_W-1:0]      eth_dest_mac,
	output logic [arc_pkg::IP_W-1:0]       out_target_ip,
	output logic [arc_pkg::MAC_W-1:0]      out_target_mac,
	output logic                           learned,
	output logic                           cache_full,
	output logic                           pending_full,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [arc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [arc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import arc_pkg::*;

	logic [IP_W-1:0]  self_ip_q;
	logic [MAC_W-1:0] self_mac_q;
	logic             cmd_valid;
	logic             cmd_pop;
	cmd_t             cmd;
	logic             res_valid;
	res_t             res;

	assign cfg_ready = 1'b1;

	// self_mac is held in a config register but drives no output of this block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_ip_q  <= '0;
			self_mac_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SELF_IP:  self_ip_q  <= cfg_data[IP_W-1:0];
				REG_SELF_MAC: self_mac_q <= cfg_data[MAC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	arc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.req_type   (req_type),
		.arp_oper   (arp_oper),
		.sender_ip  (sender_ip),
		.sender_mac (sender_mac),
		.target_ip  (target_ip),
		.resolve_ip (resolve_ip),
		.iface      (iface),
		.self_ip    (self_ip_q),
		.cmd_valid  (cmd_valid),
		.cmd_pop    (cmd_pop),
		.cmd        (cmd)
	);

	arc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_pop   (pop),
		.res       (res)
	);

	assign empty          = !res_valid;
	assign send_valid     = res.send_valid;
	assign out_oper       = res.out_oper;
	assign out_iface      = res.out_iface;
	assign eth_dest_mac   = res.eth_dest_mac;
	assign out_target_ip  = res.out_target_ip;
	assign out_target_mac = res.out_target_mac;
	assign learned        = res.learned;
	assign cache_full     = res.cache_full;
	assign pending_full   = res.pending_full;

`ifndef SYNTHESIS
	a_oper_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && send_valid) |-> (out_oper == OUT_OP_REQUEST || out_oper == OUT_OP_REPLY))
		else $error("emitted frame with bad operation");

	a_quiet_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !send_valid) |-> (out_oper == '0 && out_iface == '0 &&
		eth_dest_mac == '0 && out_target_ip == '0 && out_target_mac == '0))
		else $error("frame fields not zero without transfer of a frame");

	a_learn_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(learned && cache_full))
		else $error("learned and cache_full together");

	a_pend_full_req: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pending_full) |-> (send_valid && out_oper == OUT_OP_REQUEST &&
		!learned && !cache_full))
		else $error("pending_full outside a broadcast request");

	a_self_mac_held: assert property (@(posedge clk) disable iff (!arst_n)
		!(cfg_valid && cfg_index == REG_SELF_MAC) |=> $stable(self_mac_q))
		else $error("self_mac changed without a config transfer");
`endif

endmodule

@@ rtl/core/arc_front.sv @@
// front end: classifies incoming items and buffers commands in a two-entry queue
module arc_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic                        req_type,
	input  logic [arc_pkg::OPER_W-1:0]  arp_oper,
	input  logic [arc_pkg::IP_W-1:0]    sender_ip,
	input  logic [arc_pkg::MAC_W-1:0]   sender_mac,
	input  logic [arc_pkg::IP_W-1:0]    target_ip,
	input  logic [arc_pkg::IP_W-1:0]    resolve_ip,
	input  logic [arc_pkg::IFACE_W-1:0] iface,
	input  logic [arc_pkg::IP_W-1:0]    self_ip,
	output logic                        cmd_valid,
	input  logic                        cmd_pop,
	output arc_pkg::cmd_t               cmd
);
	import arc_pkg::*;

	cmd_t       cmd_d;
	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	always_comb begin
		cmd_d.mac   = sender_mac;
		cmd_d.ip    = sender_ip;
		cmd_d.iface = '0;
		cmd_d.kind  = CMD_NONE;
		if (req_type) begin
			cmd_d.kind  = CMD_RESOLVE;
			cmd_d.ip    = resolve_ip;
			cmd_d.iface = iface;
		end else if (target_ip == self_ip) begin
			if (arp_oper == OPER_REQUEST) begin
				cmd_d.kind = CMD_ARP_REQ;
			end else if (arp_oper == OPER_REPLY) begin
				cmd_d.kind = CMD_ARP_REPLY;
			end
		end
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;
	assign cmd       = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= cmd_d;
		end
	end

endmodule

@@ rtl/core/arc_back.sv @@
// back end: cache and pending store search, update and result register
module arc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_pop,
	input  arc_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_pop,
	output arc_pkg::res_t res
);
	import arc_pkg::*;

	back_state_t              state_q;
	back_state_t              state_d;
	cmd_t                     cur_q;
	logic [IP_W-1:0]          cache_ip_q [CACHE_DEPTH];
	logic [CACHE_CNT_W-1:0]   cache_cnt_q;
	logic [IP_W-1:0]          pend_ip_q [PENDING_DEPTH];
	logic [PENDING_DEPTH-1:0] pend_valid_q;
	logic                     cache_hit_d;
	logic                     cache_hit_q;
	logic [PENDING_DEPTH-1:0] pend_hit_d;
	logic [PENDING_DEPTH-1:0] pend_hit_q;
	logic [PENDING_DEPTH-1:0] pend_free_oh;
	logic [PENDING_DEPTH-1:0] pend_first_hit;
	logic [PENDING_DEPTH-1:0] pend_set;
	logic [PENDING_DEPTH-1:0] pend_clr;
	logic                     cache_room;
	logic                     cache_we;
	logic                     res_load;
	res_t                     res_d;
	res_t                     res_q;
	logic                     res_valid_q;

	// parallel compare against written entries only
	always_comb begin
		cache_hit_d = 1'b0;
		for (int i = 0; i < CACHE_DEPTH; i++) begin
			if ((CACHE_CNT_W'(i) < cache_cnt_q) && (cache_ip_q[i] == cur_q.ip)) begin
				cache_hit_d = 1'b1;
			end
		end
		for (int j = 0; j < PENDING_DEPTH; j++) begin
			pend_hit_d[j] = pend_valid_q[j] && (pend_ip_q[j] == cur_q.ip);
		end
	end

	assign pend_free_oh   = ~pend_valid_q & (pend_valid_q + PENDING_DEPTH'(1));
	assign pend_first_hit = pend_hit_q & (~pend_hit_q + PENDING_DEPTH'(1));
	assign cache_room     = (cache_cnt_q < CACHE_CNT_W'(CACHE_DEPTH));

	always_comb begin
		state_d  = state_q;
		cmd_pop  = 1'b0;
		res_load = 1'b0;
		res_d    = '0;
		cache_we = 1'b0;
		pend_set = '0;
		pend_clr = '0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && !res_valid_q) begin
					cmd_pop = 1'b1;
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_d  = ST_IDLE;
				res_load = 1'b1;
				case (cur_q.kind)
					CMD_ARP_REQ, CMD_ARP_REPLY: begin
						if (!cache_hit_q) begin
							if (cache_room) begin
								cache_we      = 1'b1;
								res_d.learned = 1'b1;
							end else begin
								res_d.cache_full = 1'b1;
							end
						end
						if (cur_q.kind == CMD_ARP_REQ) begin
							res_d.send_valid     = 1'b1;
							res_d.out_oper       = OUT_OP_REPLY;
							res_d.out_iface      = '0;
							res_d.eth_dest_mac   = cur_q.mac;
							res_d.out_target_ip  = cur_q.ip;
							res_d.out_target_mac = cur_q.mac;
						end else begin
							pend_clr = pend_first_hit;
						end
					end
					CMD_RESOLVE: begin
						if (pend_hit_q == '0) begin
							if (pend_free_oh != '0) begin
								pend_set = pend_free_oh;
							end else begin
								res_d.pending_full = 1'b1;
							end
							res_d.send_valid     = 1'b1;
							res_d.out_oper       = OUT_OP_REQUEST;
							res_d.out_iface      = cur_q.iface;
							res_d.eth_dest_mac   = MAC_BCAST;
							res_d.out_target_ip  = cur_q.ip;
							res_d.out_target_mac = '0;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cache_cnt_q  <= '0;
			pend_valid_q <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			pend_valid_q <= (pend_valid_q | pend_set) & ~pend_clr;
			if (cache_we) begin
				cache_cnt_q <= cache_cnt_q + CACHE_CNT_W'(1);
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd;
		end
		if (state_q == ST_SEARCH) begin
			cache_hit_q <= cache_hit_d;
			pend_hit_q  <= pend_hit_d;
		end
		if (res_load) begin
			res_q <= res_d;
		end
		for (int i = 0; i < CACHE_DEPTH; i++) begin
			if (cache_we && (cache_cnt_q[CACHE_IDX_W-1:0] == CACHE_IDX_W'(i))) begin
				cache_ip_q[i] <= cur_q.ip;
			end
		end
		for (int j = 0; j < PENDING_DEPTH; j++) begin
			if (pend_set[j]) begin
				pend_ip_q[j] <= cur_q.ip;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
